FILE: hdl/euvc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// euvc_pkg
// shared types, codes and constants of the eeprom update and verify controller
// ----------------------------------------------------------------------------
package euvc_pkg;

	// buffer depth, at most 15 so that a slot index fits in four bits
	localparam int unsigned BUF_DEPTH = 10;
	localparam logic [3:0]  BUF_DEPTH_C = 4'(BUF_DEPTH);
	localparam logic [7:0]  BUF_DEPTH_B = 8'(BUF_DEPTH);

	// reset values of the configuration registers
	localparam logic [7:0]  RD_TIMEOUT_RST = 8'd20;
	localparam logic [7:0]  WR_TIMEOUT_RST = 8'd20;
	localparam logic [15:0] LAST_ADDR_RST  = 16'd1023;

	// configuration register indexes
	localparam logic [1:0] CFG_RD_TIMEOUT = 2'd0;
	localparam logic [1:0] CFG_WR_TIMEOUT = 2'd1;
	localparam logic [1:0] CFG_LAST_ADDR  = 2'd2;

	// request codes
	localparam logic [2:0] OP_TICK      = 3'd0;
	localparam logic [2:0] OP_LOAD      = 3'd1;
	localparam logic [2:0] OP_START_UPD = 3'd2;
	localparam logic [2:0] OP_START_RD  = 3'd3;
	localparam logic [2:0] OP_FETCH     = 3'd4;

	// job kinds, also the activity code
	localparam logic [1:0] ACT_IDLE   = 2'd0;
	localparam logic [1:0] ACT_UPDATE = 2'd1;
	localparam logic [1:0] ACT_READ   = 2'd2;

	// events
	localparam logic [1:0] EV_NONE    = 2'd0;
	localparam logic [1:0] EV_DONE    = 2'd1;
	localparam logic [1:0] EV_TIMEOUT = 2'd2;
	localparam logic [1:0] EV_REJECT  = 2'd3;

	// update phases
	localparam logic [1:0] PH_WAIT   = 2'd0;
	localparam logic [1:0] PH_READ   = 2'd1;
	localparam logic [1:0] PH_WRITE  = 2'd2;
	localparam logic [1:0] PH_VERIFY = 2'd3;

	typedef struct packed {
		logic [2:0]  operation;
		logic [15:0] start_address;
		logic [7:0]  byte_count;
		logic [3:0]  buffer_index;
		logic [7:0]  data_byte;
		logic        mem_busy;
		logic [7:0]  mem_rdata;
		logic        ms_tick;
	} item_t;

	typedef struct packed {
		logic [1:0]  activity;
		logic [1:0]  event_res;
		logic [15:0] mem_addr;
		logic        mem_read;
		logic        mem_write;
		logic [7:0]  mem_wdata;
		logic [7:0]  read_byte;
		logic        read_valid;
	} result_t;

	typedef struct packed {
		logic [7:0]  read_timeout_ms;
		logic [7:0]  write_timeout_ms;
		logic [15:0] mem_last_address;
	} cfg_t;

	// buffer access request from the sequencer
	typedef struct packed {
		logic       wb_we;
		logic [3:0] wb_widx;
		logic [7:0] wb_wdata;
		logic [3:0] wb_ridx;
		logic       rb_we;
		logic [3:0] rb_widx;
		logic [7:0] rb_wdata;
		logic [3:0] rb_ridx;
	} buf_req_t;

endpackage
`default_nettype wire

FILE: hdl/euvc_buf.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// euvc_buf
// write buffer and read buffer, one write and one read port each
// ----------------------------------------------------------------------------
module euvc_buf (
	input  wire logic               clk,
	input  wire euvc_pkg::buf_req_t req,
	output logic [7:0]              wb_rdata,
	output logic [7:0]              rb_rdata
);
	import euvc_pkg::*;

	logic [7:0] wbuf_q [BUF_DEPTH];
	logic [7:0] rbuf_q [BUF_DEPTH];

	// contents undefined until written, so no reset
	always_ff @(posedge clk) begin
		if (req.wb_we) begin
			wbuf_q[req.wb_widx] <= req.wb_wdata;
		end
		if (req.rb_we) begin
			rbuf_q[req.rb_widx] <= req.rb_wdata;
		end
	end

	// out of range slots read as zero
	assign wb_rdata = (req.wb_ridx < BUF_DEPTH_C) ? wbuf_q[req.wb_ridx] : 8'd0;
	assign rb_rdata = (req.rb_ridx < BUF_DEPTH_C) ? rbuf_q[req.rb_ridx] : 8'd0;

endmodule
`default_nettype wire

FILE: hdl/euvc_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// euvc_core
// job state registers and the single step logic for one request
// ----------------------------------------------------------------------------
module euvc_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step_en,
	input  wire euvc_pkg::item_t   item,
	input  wire euvc_pkg::cfg_t    cfg,
	output euvc_pkg::result_t      res
);
	import euvc_pkg::*;

	logic [1:0]  kind_q, kind_d;
	logic [1:0]  phase_q, phase_d;
	logic        vpend_q, vpend_d;
	logic        armed_q, armed_d;
	logic [15:0] addr_q, addr_d;
	logic [3:0]  pos_q, pos_d;
	logic [3:0]  size_q, size_d;
	logic [7:0]  tleft_q, tleft_d;

	buf_req_t    breq;
	logic [7:0]  wb_rdata;
	logic [7:0]  rb_rdata;

	euvc_buf u_buf (
		.clk      (clk),
		.req      (breq),
		.wb_rdata (wb_rdata),
		.rb_rdata (rb_rdata)
	);

	always_comb begin
		logic [7:0]  tl_dec;
		logic [16:0] req_end;
		logic        pos_ok;
		logic [7:0]  slot_w;
		logic        fin;
		logic        adv;
		logic        smp;

		kind_d  = kind_q;
		phase_d = phase_q;
		vpend_d = vpend_q;
		armed_d = armed_q;
		addr_d  = addr_q;
		pos_d   = pos_q;
		size_d  = size_q;
		fin     = 1'b0;
		adv     = 1'b0;
		smp     = 1'b0;

		res            = '0;
		res.event_res  = EV_NONE;

		tl_dec  = (item.ms_tick && (tleft_q != 8'd0)) ? tleft_q - 8'd1 : tleft_q;
		tleft_d = tl_dec;
		req_end = {1'b0, item.start_address} + {9'd0, item.byte_count};
		pos_ok  = pos_q < BUF_DEPTH_C;
		slot_w  = pos_ok ? wb_rdata : 8'd0;

		breq          = '0;
		breq.wb_widx  = item.buffer_index;
		breq.wb_wdata = item.data_byte;
		breq.wb_ridx  = pos_q;
		breq.rb_widx  = pos_q;
		breq.rb_wdata = item.mem_rdata;
		breq.rb_ridx  = item.buffer_index;

		unique case (item.operation) inside
			OP_TICK: begin
				if (kind_q == ACT_UPDATE) begin
					unique case (phase_q)
						PH_WAIT: begin
							if (!item.mem_busy) begin
								phase_d = vpend_q ? PH_VERIFY : PH_READ;
							end
							if (tl_dec == 8'd0) begin
								vpend_d       = 1'b0;
								phase_d       = PH_WAIT;
								kind_d        = ACT_IDLE;
								res.event_res = EV_TIMEOUT;
							end
						end
						PH_READ: begin
							if (pos_q < size_q) begin
								res.mem_read = 1'b1;
								smp          = 1'b1;
								if (item.mem_rdata != slot_w) begin
									phase_d = PH_WRITE;
								end else begin
									adv = 1'b1;
								end
							end else begin
								fin           = 1'b1;
								res.event_res = EV_DONE;
							end
						end
						PH_WRITE: begin
							res.mem_write = 1'b1;
							res.mem_wdata = slot_w;
							tleft_d       = cfg.write_timeout_ms;
							phase_d       = PH_WAIT;
							vpend_d       = 1'b1;
						end
						default: begin
							// verify read back
							res.mem_read = 1'b1;
							smp          = 1'b1;
							if (item.mem_rdata == slot_w) begin
								adv     = 1'b1;
								phase_d = PH_READ;
							end else begin
								phase_d = PH_WRITE;
							end
						end
					endcase
				end else if (kind_q == ACT_READ) begin
					if (!armed_q) begin
						if (!item.mem_busy) begin
							armed_d = 1'b1;
						end
						if (tl_dec == 8'd0) begin
							armed_d       = 1'b0;
							kind_d        = ACT_IDLE;
							res.event_res = EV_TIMEOUT;
						end
					end else if (pos_q < size_q) begin
						res.mem_read = 1'b1;
						smp          = 1'b1;
						adv          = 1'b1;
					end else begin
						fin           = 1'b1;
						res.event_res = EV_DONE;
					end
				end
			end
			OP_LOAD: begin
				breq.wb_we = item.buffer_index < BUF_DEPTH_C;
			end
			OP_START_UPD, OP_START_RD: begin
				if (req_end >= {1'b0, cfg.mem_last_address}) begin
					res.event_res = EV_REJECT;
				end else begin
					addr_d  = item.start_address;
					pos_d   = 4'd0;
					size_d  = (item.byte_count > BUF_DEPTH_B) ? BUF_DEPTH_C
					                                          : item.byte_count[3:0];
					phase_d = PH_WAIT;
					vpend_d = 1'b0;
					armed_d = 1'b0;
					kind_d  = (item.operation == OP_START_UPD) ? ACT_UPDATE : ACT_READ;
					tleft_d = cfg.read_timeout_ms;
				end
			end
			OP_FETCH: begin
				res.read_byte  = rb_rdata;
				res.read_valid = (size_q != 4'd0) && (item.buffer_index < size_q);
			end
			default: begin
				// unused codes only age the timer
			end
		endcase

		breq.rb_we = smp && pos_ok;

		if (adv) begin
			addr_d = addr_q + 16'd1;
			pos_d  = pos_q + 4'd1;
		end
		if (fin) begin
			addr_d  = 16'd0;
			pos_d   = 4'd0;
			phase_d = PH_WAIT;
			vpend_d = 1'b0;
			armed_d = 1'b0;
			kind_d  = ACT_IDLE;
		end

		res.activity = kind_d;
		res.mem_addr = addr_d;

		if (!step_en) begin
			breq.wb_we = 1'b0;
			breq.rb_we = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q  <= ACT_IDLE;
			phase_q <= PH_WAIT;
			vpend_q <= 1'b0;
			armed_q <= 1'b0;
			addr_q  <= 16'd0;
			pos_q   <= 4'd0;
			size_q  <= 4'd0;
			tleft_q <= 8'd0;
		end else if (step_en) begin
			kind_q  <= kind_d;
			phase_q <= phase_d;
			vpend_q <= vpend_d;
			armed_q <= armed_d;
			addr_q  <= addr_d;
			pos_q   <= pos_d;
			size_q  <= size_d;
			tleft_q <= tleft_d;
		end
	end

endmodule
`default_nettype wire

FILE: hdl/eeprom_update_verify_controller_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eeprom_update_verify_controller_top
// eeprom update, verify and streamed read sequencer with stream ports
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle and returns exactly one result
// per request, in order. A request is captured in an input register, worked
// through the sequencer step logic against the job state, and the result lands
// in an output register, from which it is taken off m_tdata. One request per
// cycle is sustained while m_tready stays high, set by the single state update
// per request. While a finished result waits for m_tready, one more request is
// still taken into the input register if it is empty; with both registers full
// s_tready drops until m_tready returns. Both byte buffers are flip-flop
// arrays with no clearing pass; a slot never loaded or never filled by a read
// reads back as an undefined byte. Configuration writes are always taken
// (cfg_ready stays high) and must only be issued while idle.
// ----------------------------------------------------------------------------
module eeprom_update_verify_controller_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// start_address[15:0], byte_count[23:16], buffer_index[27:24],
	// data_byte[35:28], mem_busy[36], mem_rdata[44:37], ms_tick[45], zero fill
	input  wire logic [47:0] s_tdata,
	// operation[2:0]
	input  wire logic [2:0]  s_tuser,
	// result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// activity[1:0], event_res[3:2], mem_addr[19:4], mem_read[20],
	// mem_write[21], mem_wdata[29:22], read_byte[37:30], read_valid[38], zero fill
	output logic [39:0]      m_tdata,
	// configuration write channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);
	import euvc_pkg::*;

	// input register
	logic    vld_s1;
	item_t   item_s1;
	// output register
	logic    vld_s2;
	result_t res_s2;

	cfg_t    cfg_q;
	result_t step_res;
	logic    step_en;

	// a request is worked when the output register is free or being drained
	assign step_en  = vld_s1 && (!vld_s2 || m_tready);
	assign s_tready = !vld_s1 || step_en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	// payload capture, unpacking the stream word
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.operation     <= s_tuser;
			item_s1.start_address <= s_tdata[15:0];
			item_s1.byte_count    <= s_tdata[23:16];
			item_s1.buffer_index  <= s_tdata[27:24];
			item_s1.data_byte     <= s_tdata[35:28];
			item_s1.mem_busy      <= s_tdata[36];
			item_s1.mem_rdata     <= s_tdata[44:37];
			item_s1.ms_tick       <= s_tdata[45];
		end
	end

	// configuration registers, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.read_timeout_ms  <= RD_TIMEOUT_RST;
			cfg_q.write_timeout_ms <= WR_TIMEOUT_RST;
			cfg_q.mem_last_address <= LAST_ADDR_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_RD_TIMEOUT: cfg_q.read_timeout_ms  <= cfg_data[7:0];
				CFG_WR_TIMEOUT: cfg_q.write_timeout_ms <= cfg_data[7:0];
				CFG_LAST_ADDR:  cfg_q.mem_last_address <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// sequencer: job state plus one step of work per request
	euvc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step_en(step_en),
		.item   (item_s1),
		.cfg    (cfg_q),
		.res    (step_res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (step_en) begin
			vld_s2 <= 1'b1;
		end else if (m_tready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			res_s2 <= step_res;
		end
	end

	assign m_tvalid = vld_s2;
	assign m_tdata  = {1'b0, res_s2.read_valid, res_s2.read_byte, res_s2.mem_wdata,
	                   res_s2.mem_write, res_s2.mem_read, res_s2.mem_addr,
	                   res_s2.event_res, res_s2.activity};

	// a write to the memory only happens inside a running update, never with a read
	a_write_in_update: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && res_s2.mem_write) |-> (res_s2.activity == ACT_UPDATE && !res_s2.mem_read))
		else $error("memory write outside an update or together with a read");

	// a finished job leaves the block idle at address zero
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && res_s2.event_res == EV_DONE) |->
		(res_s2.activity == ACT_IDLE && res_s2.mem_addr == 16'd0))
		else $error("completed job did not return to idle at address zero");

	// a timed out job is always dropped
	a_timeout_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && res_s2.event_res == EV_TIMEOUT) |-> (res_s2.activity == ACT_IDLE))
		else $error("timed out job still active");

endmodule
`default_nettype wire
